@@ src/lcdws_pkg.sv @@
package lcdws_pkg;

   localparam int BIN_W      = 32;   // width of the printed number
   localparam int BCD_DIGITS = 10;   // decimal digits of a 32-bit magnitude
   localparam int BCD_W      = 4 * BCD_DIGITS;
   localparam int STEP_W     = $clog2(BIN_W);
   localparam int REMAIN_W   = $clog2(BCD_DIGITS + 1);

   localparam logic [7:0] CHAR_ZERO       = 8'h30;
   localparam logic [7:0] CHAR_MINUS      = 8'h2D;
   localparam logic [7:0] CMD_FUNC_SET_8  = 8'h38;
   localparam logic [7:0] CMD_DISPLAY_ON  = 8'h0C;
   localparam logic [7:0] CMD_CLEAR       = 8'h01;
   localparam logic [3:0] NIB_FUNC_SET_4  = 4'h2;
   localparam logic [3:0] NIB_TWO_LINES   = 4'h8;
   localparam logic       MODE_RESET      = 1'b1;

   typedef enum logic [2:0] {
      OP_CMD    = 3'd0,
      OP_DATA   = 3'd1,
      OP_CURSOR = 3'd2,
      OP_NUMBER = 3'd3,
      OP_INIT   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_LOAD,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic [2:0]        opcode;
      logic [7:0]        byte_value;
      logic [5:0]        column;
      logic              row;
      logic signed [31:0] number;
   } req_type;

   typedef struct packed {
      logic       register_select;
      logic [7:0] bus_value;
      logic       last_write;
   } rsp_type;

   // one byte (or one lone nibble) waiting to go out on the bus
   typedef struct packed {
      logic       rs;
      logic       raw;    // single nibble beat, no pair
      logic       last;
      logic [7:0] value;
   } item_type;

   typedef struct packed {
      logic start;
      logic shift_digit;
   } bcd_ctrl_type;

   // power-up command run; step counts loaded items
   function automatic item_type init_item(input logic [2:0] step, input logic four);
      item_type it;
      it = '{rs: 1'b0, raw: 1'b0, last: 1'b0, value: CMD_CLEAR};
      if (four) begin
         unique case (step)
            3'd0, 3'd1: begin
               it.raw   = 1'b1;
               it.value = {4'h0, NIB_FUNC_SET_4};
            end
            3'd2: begin
               it.raw   = 1'b1;
               it.value = {4'h0, NIB_TWO_LINES};
            end
            3'd3: it.value = CMD_DISPLAY_ON;
            default: it.last = 1'b1;
         endcase
      end else begin
         unique case (step)
            3'd0: it.value = CMD_FUNC_SET_8;
            3'd1: it.value = CMD_DISPLAY_ON;
            default: it.last = 1'b1;
         endcase
      end
      return it;
   endfunction

endpackage

@@ src/lcdws_bcd.sv @@
module lcdws_bcd
   import lcdws_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  bcd_ctrl_type     ctrl,
   input  logic [BIN_W-1:0] magnitude,
   output logic             busy,
   output logic [3:0]       top_digit
);

   logic [BIN_W-1:0]  bin_ff, bin_in;
   logic [BCD_W-1:0]  bcd_ff, bcd_in, bcd_adj;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;

   // shift-add-3: each digit of 5 or more gets 3 before the shift
   always_comb begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
         bcd_adj[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ?
                             bcd_ff[4*d +: 4] + 4'd3 : bcd_ff[4*d +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      priority if (ctrl.start) begin
         bin_in  = magnitude;
         bcd_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = {bcd_adj[BCD_W-2:0], bin_ff[BIN_W-1]};
         bin_in  = {bin_ff[BIN_W-2:0], 1'b0};
         cnt_in  = cnt_ff + 1'b1;
         busy_in = (cnt_ff != STEP_W'(BIN_W - 1));
      end else if (ctrl.shift_digit) begin
         bcd_in  = {bcd_ff[BCD_W-5:0], 4'h0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
      cnt_ff <= cnt_in;
   end

   assign busy      = busy_ff;
   assign top_digit = bcd_ff[BCD_W-1 -: 4];

endmodule

@@ src/char_lcd_write_sequencer.sv @@
// Character LCD write sequencer: one request in, a run of bus write beats out.
// A request goes through the load and send states before its first beat is registered
// (cmd/data/cursor/init); a number first passes conversion and the leading-zero skip.
// One request at a time; each byte has a load state, then goes out as one beat (8-bit) or
// a high and low nibble pair (4-bit); init nibble steps go out as one lone nibble beat.
// Reset (synchronous, active high): idle, output empty, nibble mode on.
module char_lcd_write_sequencer
   import lcdws_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   // request channel
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   // write beat channel
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data,
   // mode register
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   state_type           state_ff, state_in;
   op_type              op_ff, op_in;
   logic [7:0]          byte_value_ff, byte_value_in;
   logic [5:0]          column_ff, column_in;
   logic                row_ff, row_in;
   logic                neg_ff, neg_in;        // minus sign still to send
   logic [REMAIN_W-1:0] remain_ff, remain_in;  // digits left in the BCD word
   logic [2:0]          step_ff, step_in;      // init run position
   item_type            cur_ff, cur_in;        // byte being sent
   logic                half_ff, half_in;      // high nibble already sent
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                mode_ff, mode_in;

   logic                accept;
   logic                out_free;
   logic                byte_done;
   logic                skip_zero;
   logic                emit;
   logic                load;
   logic [BIN_W-1:0]    magnitude;
   logic                bcd_busy;
   logic [3:0]          top_digit;
   bcd_ctrl_type        bcd_ctrl;

   // mode register, always writable
   assign csr_ready = 1'b1;
   assign mode_in   = (csr_valid && csr_ready) ? csr_data : mode_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   // output register frees when empty or its beat is taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // a byte ends on its only beat, or on the low nibble of a pair
   assign byte_done = !mode_ff || cur_ff.raw || half_ff;
   // leading zeros dropped, keeping at least one digit so zero prints "0"
   assign skip_zero = (top_digit == 4'h0) && (remain_ff > REMAIN_W'(1));

   // the most negative value wraps to its own unsigned magnitude
   assign magnitude = req_data.number[BIN_W-1] ? BIN_W'(0) - BIN_W'(req_data.number)
                                               : BIN_W'(req_data.number);

   lcdws_bcd u_bcd (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (bcd_ctrl),
      .magnitude (magnitude),
      .busy      (bcd_busy),
      .top_digit (top_digit)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               priority case (req_data.opcode)
                  OP_CMD, OP_DATA, OP_CURSOR, OP_INIT: state_in = ST_LOAD;
                  OP_NUMBER:                           state_in = ST_CONV;
                  default:                             state_in = ST_IDLE;
               endcase
            end
         end
         ST_CONV: begin
            if (!bcd_busy) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (!skip_zero) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: state_in = ST_SEND;
         ST_SEND: begin
            if (out_free && byte_done) begin
               state_in = cur_ff.last ? ST_IDLE : ST_LOAD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------- control outputs ----------------
   always_comb begin
      bcd_ctrl = '{start: 1'b0, shift_digit: 1'b0};
      load     = 1'b0;
      emit     = 1'b0;
      unique case (state_ff)
         ST_IDLE: bcd_ctrl.start = accept && (req_data.opcode == OP_NUMBER);
         ST_CONV: ;
         ST_SKIP: bcd_ctrl.shift_digit = skip_zero;
         ST_LOAD: begin
            load = 1'b1;
            bcd_ctrl.shift_digit = (op_ff == OP_NUMBER) && !neg_ff;
         end
         ST_SEND: emit = out_free;
         default: ;
      endcase
   end

   // ---------------- datapath ----------------
   always_comb begin
      op_in         = op_ff;
      byte_value_in = byte_value_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      neg_in        = neg_ff;
      remain_in     = remain_ff;
      step_in       = step_ff;
      cur_in        = cur_ff;
      half_in       = half_ff;

      if (accept) begin
         op_in         = op_type'(req_data.opcode);
         byte_value_in = req_data.byte_value;
         column_in     = req_data.column;
         row_in        = req_data.row;
         neg_in        = req_data.number[BIN_W-1];
         remain_in     = REMAIN_W'(BCD_DIGITS);
         step_in       = '0;
      end

      if (state_ff == ST_SKIP && skip_zero) begin
         remain_in = remain_ff - 1'b1;
      end

      if (load) begin
         half_in = 1'b0;
         cur_in  = '{rs: 1'b0, raw: 1'b0, last: 1'b1, value: byte_value_ff};
         priority case (op_ff)
            OP_CMD: ;
            OP_DATA: cur_in.rs = 1'b1;
            // DDRAM address: row 1 starts at 0x40, column below 64
            OP_CURSOR: cur_in.value = {1'b1, row_ff, column_ff};
            OP_NUMBER: begin
               cur_in.rs = 1'b1;
               if (neg_ff) begin
                  cur_in.value = CHAR_MINUS;
                  cur_in.last  = 1'b0;
                  neg_in       = 1'b0;
               end else begin
                  cur_in.value = CHAR_ZERO | {4'h0, top_digit};
                  cur_in.last  = (remain_ff == REMAIN_W'(1));
                  remain_in    = remain_ff - 1'b1;
               end
            end
            OP_INIT: begin
               cur_in  = init_item(step_ff, mode_ff);
               step_in = step_ff + 1'b1;
            end
            default: ;
         endcase
      end

      if (emit) begin
         half_in = !byte_done;
      end
   end

   // output register: loads a beat, or empties once its beat is taken
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (emit) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.register_select = cur_ff.rs;
         rsp_data_in.last_write      = cur_ff.last && byte_done;
         priority if (!mode_ff) begin
            rsp_data_in.bus_value = cur_ff.value;
         end else if (cur_ff.raw || half_ff) begin
            rsp_data_in.bus_value = {4'h0, cur_ff.value[3:0]};
         end else begin
            rsp_data_in.bus_value = {4'h0, cur_ff.value[7:4]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_RESET;
         half_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mode_ff      <= mode_in;
         half_ff      <= half_in;
      end
      op_ff         <= op_in;
      byte_value_ff <= byte_value_in;
      column_ff     <= column_in;
      row_ff        <= row_in;
      neg_ff        <= neg_in;
      remain_ff     <= remain_in;
      step_ff       <= step_in;
      cur_ff        <= cur_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
